@@ rtl/stream_mode_finder_top_assert.svh @@
// Assertion macros for the stream mode finder checker.
// Used by smf_chk.sv; expects clk and rst in scope.
`ifndef STREAM_MODE_FINDER_TOP_ASSERT_SVH
`define STREAM_MODE_FINDER_TOP_ASSERT_SVH

// Checked outside reset.
`define SMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SMF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/smf_pkg.sv @@
// Shared constants and helpers for the stream mode finder.
// No dependencies.
`default_nettype none

package smf_pkg;

  localparam int SYM_W         = 8;
  localparam int NUM_SYMS      = 1 << SYM_W;
  localparam int MAX_ITEMS_DEF = 1024;

  // Result tdata: mode_symbol then mode_count, padded to whole bytes.
  function automatic int out_tdata_w(input int cnt_w);
    return ((SYM_W + cnt_w + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stream_mode_finder_top.sv @@
// Stream mode finder: top level with count store and running leader.
// Depends on smf_pkg.
//
// Takes one 8-bit symbol per request on the s_ side; the request with tlast
// closes a sequence and yields one result on the m_ side: the most frequent
// symbol of the sequence and its count (ties go to the symbol seen first).
// Counts and the count in the result saturate at MAX_ITEMS; positions past
// MAX_ITEMS-1 all share the last position. Throughput is one request per
// cycle while s_tready is high. That rate is set by the single
// read-modify-write of the per-symbol store: the read is registered at
// accept, the update and leader compare happen as the stage completes, and a
// forwarding register covers a repeat of the same symbol in consecutive
// requests. Stores and leader clear at once after reset and after every last
// request (valid bit per symbol), so no clearing pass is needed. s_tready
// drops only while a result waits in the output register and a further last
// request is ready to produce another.
`default_nettype none

module stream_mode_finder_top #(
  parameter int MAX_ITEMS = smf_pkg::MAX_ITEMS_DEF,
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
  localparam int OUT_W    = smf_pkg::out_tdata_w(CNT_W)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [smf_pkg::SYM_W-1:0] s_tdata,  // [7:0] symbol
  input  wire logic                    s_tlast,    // last symbol of the sequence
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_W-1:0]             m_tdata     // mode_symbol, mode_count, zero pad
);

  localparam int SYM_W = smf_pkg::SYM_W;
  localparam int NSYM  = smf_pkg::NUM_SYMS;
  localparam int POS_W = $clog2(MAX_ITEMS);
  localparam int ENT_W = CNT_W + POS_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_ITEMS - 1);

  // Per-symbol store: {count, first position}
  logic [ENT_W-1:0] mem [NSYM];
  logic [NSYM-1:0]  valid;

  // Stage register: accepted request plus its store read
  logic             p_valid;
  logic [SYM_W-1:0] p_sym;
  logic             p_last;
  logic [ENT_W-1:0] p_rd;
  logic             p_rd_valid;

  // Most recently completed request, for forwarding
  logic             fwd_valid;
  logic             fwd_last;
  logic [SYM_W-1:0] fwd_sym;
  logic [CNT_W-1:0] fwd_cnt;
  logic [POS_W-1:0] fwd_first;

  // Sequence state
  logic [POS_W-1:0] position;
  logic [SYM_W-1:0] leader_symbol;
  logic [CNT_W-1:0] leader_count;
  logic [POS_W-1:0] leader_first;

  logic [SYM_W-1:0] leader_symbol_next;
  logic [CNT_W-1:0] leader_count_next;
  logic [POS_W-1:0] leader_first_next;

  logic             out_free;
  logic             done;
  logic             accept;
  logic [CNT_W-1:0] cur_cnt;
  logic [POS_W-1:0] cur_first;
  logic [CNT_W-1:0] new_cnt;
  logic [POS_W-1:0] new_first;

  // Handshake
  assign out_free = !m_tvalid || m_tready;
  assign done     = p_valid && (!p_last || out_free);
  assign s_tready = !p_valid || done;
  assign accept   = s_tvalid && s_tready;

  // Current entry: forwarding covers a write landing on the read edge
  always_comb begin
    priority if (fwd_valid && fwd_last) begin
      cur_cnt   = '0;
      cur_first = p_rd[POS_W-1:0];
    end else if (fwd_valid && fwd_sym == p_sym) begin
      cur_cnt   = fwd_cnt;
      cur_first = fwd_first;
    end else if (p_rd_valid) begin
      cur_cnt   = p_rd[ENT_W-1:POS_W];
      cur_first = p_rd[POS_W-1:0];
    end else begin
      cur_cnt   = '0;
      cur_first = p_rd[POS_W-1:0];
    end
  end

  assign new_first = (cur_cnt == '0) ? position : cur_first;
  assign new_cnt   = (cur_cnt < CNT_MAX) ? cur_cnt + CNT_W'(1) : cur_cnt;

  // Leader update; equal count and equal first keeps the current leader
  always_comb begin
    leader_symbol_next = leader_symbol;
    leader_count_next  = leader_count;
    leader_first_next  = leader_first;
    priority if (p_sym == leader_symbol && leader_count != '0) begin
      leader_count_next = new_cnt;
    end else if (new_cnt > leader_count ||
                 (new_cnt == leader_count && new_first < leader_first)) begin
      leader_symbol_next = p_sym;
      leader_count_next  = new_cnt;
      leader_first_next  = new_first;
    end
  end

  // Store read at accept, write at completion
  always_ff @(posedge clk) begin
    if (accept) begin
      p_rd       <= mem[s_tdata];
      p_rd_valid <= valid[s_tdata];
      p_sym      <= s_tdata;
      p_last     <= s_tlast;
    end
    if (done) begin
      mem[p_sym] <= {new_cnt, new_first};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (done && p_last) begin
      valid <= '0;
    end else if (done) begin
      valid[p_sym] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (done) begin
      p_valid <= 1'b0;
    end
  end

  // Forwarding record
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (done) begin
      fwd_valid <= 1'b1;
    end
    if (done) begin
      fwd_last  <= p_last;
      fwd_sym   <= p_sym;
      fwd_cnt   <= new_cnt;
      fwd_first <= new_first;
    end
  end

  // Sequence state: cleared after every last request
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      leader_symbol <= '0;
      leader_count  <= '0;
      leader_first  <= '0;
    end else if (done && p_last) begin
      position      <= '0;
      leader_symbol <= '0;
      leader_count  <= '0;
      leader_first  <= '0;
    end else if (done) begin
      if (position < POS_MAX) begin
        position <= position + POS_W'(1);
      end
      leader_symbol <= leader_symbol_next;
      leader_count  <= leader_count_next;
      leader_first  <= leader_first_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && p_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (done && p_last) begin
      m_tdata <= OUT_W'({leader_count_next, leader_symbol_next});
    end
  end

endmodule

`default_nettype wire

@@ rtl/smf_chk.sv @@
// Port-level checker for the stream mode finder, with its bind.
// Depends on smf_pkg and stream_mode_finder_top_assert.svh.
`default_nettype none

`include "stream_mode_finder_top_assert.svh"

module smf_chk #(
  parameter int MAX_ITEMS = smf_pkg::MAX_ITEMS_DEF,
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
  localparam int OUT_W    = smf_pkg::out_tdata_w(CNT_W)
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      s_tlast,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [OUT_W-1:0]          m_tdata
);

  localparam int SYM_W = smf_pkg::SYM_W;

  logic in_last_acc;
  logic res_stall;
  logic [CNT_W-1:0] res_count;

  assign in_last_acc = s_tvalid && s_tready && s_tlast;
  assign res_stall   = m_tvalid && !m_tready;
  assign res_count   = m_tdata[SYM_W +: CNT_W];

  // stalled result holds
  `SMF_ASSERT(a_res_hold, res_stall |=> m_tvalid && $stable(m_tdata), "result changed in stall")
  // no result right after reset
  `SMF_ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> !m_tvalid, "result valid after reset")
  // a result always counts at least one symbol
  `SMF_ASSERT(a_count_nz, m_tvalid |-> res_count != '0, "zero mode count")
  // a new result follows an accepted last request through the stage register
  `SMF_ASSERT(a_res_src, $rose(m_tvalid) |-> $past(in_last_acc, 2), "orphan result")
  // back pressure only while the result register is stalled
  `SMF_ASSERT(a_ready_stall, !s_tready |-> res_stall, "input stalled without output stall")

endmodule

bind stream_mode_finder_top smf_chk #(.MAX_ITEMS(MAX_ITEMS)) u_smf_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for stream_mode_finder_top: random and directed symbol sequences,
// with a built-in mode predictor and an in-order check of every result.
// Depends on smf_pkg and the stream_mode_finder_top RTL.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_ITEMS = smf_pkg::MAX_ITEMS_DEF;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int POS_W     = $clog2(MAX_ITEMS);
  localparam int OUT_W     = smf_pkg::out_tdata_w(CNT_W);
  localparam int SYM_W     = smf_pkg::SYM_W;
  localparam int RAND_ITEMS  = 380;
  localparam int CALM_LEFT   = 100;   // no idling once this few requests remain
  localparam int HOLD_CYCLES = 120;   // long receiver hold-off
  localparam int WATCHDOG    = 3000;  // cycles with no handshake at all

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             drain_first;  // wait for all results before offering
  } sym_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] mode_symbol;
    logic [CNT_W-1:0] mode_count;
  } mode_res_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [SYM_W-1:0] s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  sym_req_t  sym_q[$];
  mode_res_t pending_modes[$];
  int        fail_cnt = 0;
  logic      calm = 1'b0;
  logic      timed_out = 1'b0;
  int        idle_cycles = 0;

  // predictor state
  logic [CNT_W-1:0] sym_count [1 << SYM_W];
  logic [POS_W-1:0] sym_first [1 << SYM_W];
  logic [POS_W-1:0] seq_pos;
  logic [SYM_W-1:0] lead_sym;
  logic [CNT_W-1:0] lead_cnt;
  logic [POS_W-1:0] lead_first;

  stream_mode_finder_top #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] symbol
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [7:0] mode_symbol, [18:8] mode_count, zero pad
  );

  initial forever #6 clk = ~clk;

  function automatic void clear_tally();
    for (int i = 0; i < (1 << SYM_W); i++) begin
      sym_count[i] = '0;
      sym_first[i] = '0;
    end
    seq_pos    = '0;
    lead_sym   = '0;
    lead_cnt   = '0;
    lead_first = '0;
  endfunction

  // Running-mode update for one symbol; returns 1 with the mode on a last request.
  function automatic bit tally_symbol(input logic [SYM_W-1:0] sym, input logic last,
                                      output mode_res_t res);
    logic [CNT_W-1:0] c;
    logic [POS_W-1:0] f;
    c = sym_count[sym];
    if (c == 0) sym_first[sym] = seq_pos;
    f = sym_first[sym];
    if (c < MAX_ITEMS) c = c + 1'b1;
    sym_count[sym] = c;
    // the leader only refreshes its count; ties on first position keep the leader
    if (sym == lead_sym && lead_cnt != 0) begin
      lead_cnt = c;
    end else if (c > lead_cnt || (c == lead_cnt && f < lead_first)) begin
      lead_sym   = sym;
      lead_cnt   = c;
      lead_first = f;
    end
    if (seq_pos < MAX_ITEMS - 1) seq_pos = seq_pos + 1'b1;
    res = '0;
    if (!last) return 1'b0;
    res.mode_symbol = lead_sym;
    res.mode_count  = lead_cnt;
    clear_tally();
    return 1'b1;
  endfunction

  task automatic add_req(input logic [SYM_W-1:0] sym, input bit last, input bit drain = 0);
    sym_req_t r;
    r.symbol      = sym;
    r.last        = last;
    r.drain_first = drain;
    sym_q.push_back(r);
  endtask

  // Request driver: holds tvalid until accepted, random gap bursts between requests.
  always @(posedge clk) begin : drive
    mode_res_t res;
    bit        took;
    int        snd_gap;
    bit        snd_gaps_on;
    if (rst) begin
      s_tvalid    <= 1'b0;
      snd_gap     = 0;
      snd_gaps_on = 1'b1;
      clear_tally();
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        if (tally_symbol(sym_q[0].symbol, sym_q[0].last, res)) pending_modes.push_back(res);
        void'(sym_q.pop_front());
      end
      if (!s_tvalid || took) begin
        if ($urandom_range(0, 63) == 0) snd_gaps_on = !snd_gaps_on;
        if (snd_gap > 0) begin
          snd_gap--;
          s_tvalid <= 1'b0;
        end else if (sym_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (sym_q[0].drain_first && pending_modes.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if (snd_gaps_on && !calm && $urandom_range(0, 5) == 0) begin
          snd_gap  = $urandom_range(0, 17);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= sym_q[0].symbol;
          s_tlast  <= sym_q[0].last;
        end
      end
      calm <= (sym_q.size() < CALM_LEFT);
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin : observe
    mode_res_t exp;
    int        got_cnt;
    int        hold_left;
    bit        held;
    bit        rcv_gaps_on;
    if (rst) begin
      m_tready    <= 1'b0;
      got_cnt     = 0;
      hold_left   = 0;
      held        = 1'b0;
      rcv_gaps_on = 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        got_cnt++;
        if (pending_modes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual symbol %0d count %0d",
                   $time, m_tdata[SYM_W-1:0], m_tdata[SYM_W +: CNT_W]);
          fail_cnt++;
        end else begin
          exp = pending_modes.pop_front();
          if (m_tdata[SYM_W-1:0] !== exp.mode_symbol) begin
            $display("%0t: mode_symbol mismatch, expected %0d, actual %0d",
                     $time, exp.mode_symbol, m_tdata[SYM_W-1:0]);
            fail_cnt++;
          end
          if (m_tdata[SYM_W +: CNT_W] !== exp.mode_count) begin
            $display("%0t: mode_count mismatch, expected %0d, actual %0d",
                     $time, exp.mode_count, m_tdata[SYM_W +: CNT_W]);
            fail_cnt++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) rcv_gaps_on = !rcv_gaps_on;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (got_cnt >= 4 && !held) begin
        // back-pressure while short sequences keep arriving: input must stall
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready  <= 1'b0;
      end else if (rcv_gaps_on && !calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 17);
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               n_rand;
    int               len;
    int               kind;
    int               n_tail;
    bit               drain_mid;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;

    // Directed: one-request sequences, including the symbol extremes (these also
    // pile up behind the long receiver hold-off).
    add_req(8'h00, 1);
    add_req(8'hFF, 1);
    add_req(8'hA5, 1);
    add_req(8'h5A, 1);
    add_req(8'h80, 1);
    add_req(8'h01, 1);
    // tie on count: earliest first occurrence wins back the lead
    add_req(8'd3, 0); add_req(8'd7, 0); add_req(8'd7, 0); add_req(8'd3, 1);
    // later symbol overtakes
    add_req(8'd9, 0); add_req(8'd4, 0); add_req(8'd4, 1);
    // leader seen again, back to back
    add_req(8'd8, 0); add_req(8'd8, 0); add_req(8'd8, 1);
    // equal counts throughout: first symbol keeps the lead
    add_req(8'hFE, 0); add_req(8'h7F, 0); add_req(8'h02, 1);
    add_req(8'hC3, 0); add_req(8'hC3, 1);

    // Random sequences; first one waits until the directed results are in.
    n_rand    = 0;
    drain_mid = 1'b0;
    while (n_rand < RAND_ITEMS) begin
      kind = $urandom_range(0, 3);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      base = SYM_W'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        case (kind)
          0:       sym = SYM_W'($urandom_range(0, 255));
          1:       sym = base + SYM_W'($urandom_range(0, 3));
          2:       sym = (i % 2) ? ~base : base;   // alternating pair, many ties
          default: sym = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, 255)) : base;
        endcase
        add_req(sym, i == len - 1,
                (n_rand == 0) || (i == 0 && n_rand >= RAND_ITEMS / 2 && !drain_mid));
        if (i == 0 && n_rand >= RAND_ITEMS / 2) drain_mid = 1'b1;
        n_rand++;
      end
    end

    // Tail, run with no idling on either side.
    n_tail = 0;
    while (n_tail < CALM_LEFT) begin
      len  = $urandom_range(1, 8);
      base = SYM_W'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        sym = ($urandom_range(0, 1) == 0) ? base : SYM_W'($urandom_range(0, 255));
        add_req(sym, i == len - 1);
        n_tail++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && (sym_q.size() != 0 || s_tvalid || pending_modes.size() != 0))
      @(negedge clk);
    if (!timed_out) repeat (8) @(negedge clk);
    if (!timed_out && fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
